// ===== src/tpa_pkg.sv =====
`default_nettype none
package tpa_pkg;

	localparam logic [15:0] RESTART_INDEX  = 16'hFFFF;
	localparam logic [16:0] COUNT_RESET    = 17'h10000;
	localparam logic [16:0] COUNT_MASK     = 17'h1FFFF;
	localparam int          PADDR_W        = 3;
	// register index is paddr[2]; low address bits are ignored
	localparam logic        REG_VERTEX_COUNT = 1'b0;

	typedef struct packed {
		logic [15:0] index_value;
		logic        list_mode;
		logic        strip_end;
	} idx_item_t;

	typedef struct packed {
		logic [15:0] corner_a;
		logic [15:0] corner_b;
		logic [15:0] corner_c;
	} tri_item_t;

	function automatic logic triangle_ok(
		input logic [15:0] a,
		input logic [15:0] b,
		input logic [15:0] c,
		input logic [16:0] limit
	);
		logic restart_hit;
		logic repeat_hit;
		logic bound_hit;
		restart_hit = (a == RESTART_INDEX) || (b == RESTART_INDEX) || (c == RESTART_INDEX);
		repeat_hit  = (a == b) || (b == c) || (a == c);
		bound_hit   = ({1'b0, a} >= limit) || ({1'b0, b} >= limit) || ({1'b0, c} >= limit);
		return !(restart_hit || repeat_hit || bound_hit);
	endfunction

endpackage
`default_nettype wire

// ===== src/tpa_cfg.sv =====
`default_nettype none
module tpa_cfg
	import tpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output logic [16:0]             vertex_count
);

	logic [16:0] vertex_count_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= COUNT_RESET;
		end else if (wr_en && (paddr[2] == REG_VERTEX_COUNT)) begin
			vertex_count_q <= pwdata[16:0] & COUNT_MASK;
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_VERTEX_COUNT: prdata = {15'd0, vertex_count_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign vertex_count = vertex_count_q;

endmodule
`default_nettype wire

// ===== src/tpa_window.sv =====
`default_nettype none
module tpa_window
	import tpa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire idx_item_t   item,
	input  wire logic [16:0] vertex_count,
	output logic             emit,
	output tri_item_t        tri_out
);

	logic [15:0] older_q;
	logic [15:0] newer_q;
	logic [1:0]  fill_q;
	logic        odd_q;

	logic [15:0] older_d;
	logic [15:0] newer_d;
	logic [1:0]  fill_d;
	logic        odd_d;
	logic [15:0] a;
	logic [15:0] b;
	logic        formed;
	logic        full;

	assign full = (fill_q >= 2'd2);

	always_comb begin
		older_d = older_q;
		newer_d = newer_q;
		fill_d  = fill_q;
		odd_d   = odd_q;
		a       = older_q;
		b       = newer_q;
		formed  = 1'b0;

		if (item.list_mode) begin
			if (full) begin
				formed = 1'b1;
				fill_d = 2'd0;
			end else begin
				older_d = newer_q;
				newer_d = item.index_value;
				fill_d  = fill_q + 2'd1;
			end
		end else if (item.index_value == RESTART_INDEX) begin
			fill_d = 2'd0;
			odd_d  = 1'b0;
		end else begin
			if (full) begin
				formed = 1'b1;
				// odd windows swap the first two corners to keep winding
				if (odd_q) begin
					a = newer_q;
					b = older_q;
				end
				odd_d = ~odd_q;
			end else begin
				fill_d = fill_q + 2'd1;
			end
			older_d = newer_q;
			newer_d = item.index_value;
		end

		if (item.strip_end) begin
			older_d = 16'd0;
			newer_d = 16'd0;
			fill_d  = 2'd0;
			odd_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= 16'd0;
			newer_q <= 16'd0;
			fill_q  <= 2'd0;
			odd_q   <= 1'b0;
		end else if (accept) begin
			older_q <= older_d;
			newer_q <= newer_d;
			fill_q  <= fill_d;
			odd_q   <= odd_d;
		end
	end

	assign emit             = accept && formed &&
	                          triangle_ok(a, b, item.index_value, vertex_count);
	assign tri_out.corner_a = a;
	assign tri_out.corner_b = b;
	assign tri_out.corner_c = item.index_value;

endmodule
`default_nettype wire

// ===== src/tpa_out_reg.sv =====
`default_nettype none
module tpa_out_reg
	import tpa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire tri_item_t push_item,
	output logic           room,
	output logic           out_valid,
	input  wire logic      out_ready,
	output tri_item_t      out_item
);

	logic      main_valid_q;
	logic      skid_valid_q;
	tri_item_t main_q;
	tri_item_t skid_q;
	logic      pop;

	assign pop  = main_valid_q && out_ready;
	assign room = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (main_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end else if (pop) begin
				// skid item moves up, else the output empties
				main_valid_q <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_item;
			end else begin
				main_q <= push_item;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

	assign out_valid = main_valid_q;
	assign out_item  = main_q;

endmodule
`default_nettype wire

// ===== src/triangle_primitive_assembler.sv =====
// channel   dir  handshake              payload
// idx       in   idx_valid/idx_ready    idx_item   (index_value, list_mode, strip_end)
// tri       out  tri_valid/tri_ready    tri_item   (corner_a, corner_b, corner_c)
// apb       in   psel/penable/pready    paddr, pwdata, prdata (vertex_count at 0x0)
//
// One index item per cycle while idx_ready is high; each triangle is registered before it leaves.
// The window registers update at accept; the triangle checks run between them
// and the output register. A one-entry skid behind the output register takes one triangle
// while the output stalls, so idx_ready drops only while the skid holds an item.
// Reset clears the window, parity and both output slots; vertex_count resets to 65536.
`default_nettype none
module triangle_primitive_assembler
	import tpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               idx_valid,
	output logic                    idx_ready,
	input  wire idx_item_t          idx_item,
	output logic                    tri_valid,
	input  wire logic               tri_ready,
	output tri_item_t               tri_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [16:0] vertex_count;
	logic        accept;
	logic        emit;
	logic        room;
	tri_item_t   tri_new;

	assign idx_ready = room;
	assign accept    = idx_valid && idx_ready;

	tpa_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.vertex_count (vertex_count)
	);

	tpa_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (idx_item),
		.vertex_count (vertex_count),
		.emit         (emit),
		.tri_out      (tri_new)
	);

	tpa_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_item (tri_new),
		.room      (room),
		.out_valid (tri_valid),
		.out_ready (tri_ready),
		.out_item  (tri_item)
	);

endmodule
`default_nettype wire

// ===== src/tpa_checker.sv =====
`default_nettype none
module tpa_props
	import tpa_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      idx_valid,
	input wire logic      idx_ready,
	input wire logic      tri_valid,
	input wire logic      tri_ready,
	input wire tri_item_t tri_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid && !tri_ready |=> tri_valid)
		else $error("tri item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid && !tri_ready |=> $stable(tri_item))
		else $error("tri item changed while stalled");

	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		tri_valid |-> (tri_item.corner_a != tri_item.corner_b) &&
		              (tri_item.corner_b != tri_item.corner_c) &&
		              (tri_item.corner_a != tri_item.corner_c) &&
		              (tri_item.corner_c != RESTART_INDEX))
		else $error("degenerate or restart triangle emitted");

	a_caused: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tri_valid) |-> $past(idx_valid && idx_ready))
		else $error("triangle appeared without an accepted index");

endmodule

bind triangle_primitive_assembler tpa_props u_tpa_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.idx_valid (idx_valid),
	.idx_ready (idx_ready),
	.tri_valid (tri_valid),
	.tri_ready (tri_ready),
	.tri_item  (tri_item)
);
`default_nettype wire

// ===== tb/sv/tpa_checker.sv =====
`timescale 1ns / 100ps
module tpa_checker
	import tpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               idx_valid,
	input  logic               idx_ready,
	input  idx_item_t          idx_item,
	input  logic               tri_valid,
	input  logic               tri_ready,
	input  tri_item_t          tri_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 backlog,
	output int                 fail_count
);

	logic [16:0] vc_limit;
	logic [15:0] win_old;
	logic [15:0] win_new;
	logic [1:0]  win_fill;
	logic        win_odd;
	tri_item_t   expected_tris [$];

	initial fail_count = 0;

	function automatic bit corners_drawable(
		input logic [15:0] a,
		input logic [15:0] b,
		input logic [15:0] c,
		input logic [16:0] lim
	);
		if (a == RESTART_INDEX || b == RESTART_INDEX || c == RESTART_INDEX)
			return 1'b0;
		if (a == b || a == c || b == c)
			return 1'b0;
		return ({1'b0, a} < lim) && ({1'b0, b} < lim) && ({1'b0, c} < lim);
	endfunction

	task automatic clear_window();
		win_old  = '0;
		win_new  = '0;
		win_fill = '0;
		win_odd  = 1'b0;
	endtask

	// one accepted index -> zero or one expected triangle
	task automatic assemble(input idx_item_t it);
		logic [15:0] a;
		logic [15:0] b;
		bit          emit;
		tri_item_t   t;
		a    = '0;
		b    = '0;
		emit = 1'b0;
		if (it.list_mode) begin
			if (win_fill == 2'd2) begin
				a        = win_old;
				b        = win_new;
				win_fill = '0;
				emit     = corners_drawable(a, b, it.index_value, vc_limit);
			end else begin
				win_old  = win_new;
				win_new  = it.index_value;
				win_fill = win_fill + 2'd1;
			end
		end else if (it.index_value == RESTART_INDEX) begin
			win_fill = '0;
			win_odd  = 1'b0;
		end else begin
			if (win_fill == 2'd2) begin
				// odd windows swap the first two corners to keep winding
				a       = win_odd ? win_new : win_old;
				b       = win_odd ? win_old : win_new;
				win_odd = ~win_odd;
				emit    = corners_drawable(a, b, it.index_value, vc_limit);
			end else begin
				win_fill = win_fill + 2'd1;
			end
			win_old = win_new;
			win_new = it.index_value;
		end
		if (emit) begin
			t.corner_a = a;
			t.corner_b = b;
			t.corner_c = it.index_value;
			expected_tris.insert(expected_tris.size(), t);
		end
		if (it.strip_end)
			clear_window();
	endtask

	task automatic check_triangle(input tri_item_t got);
		tri_item_t want;
		if (expected_tris.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected triangle a=%0d b=%0d c=%0d",
					got.corner_a, got.corner_b, got.corner_c);
		end else begin
			want = expected_tris.pop_front();
			if (want.corner_a !== got.corner_a || want.corner_b !== got.corner_b ||
				want.corner_c !== got.corner_c) begin
				fail_count++;
				if (fail_count <= 10)
					$display("mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
						want.corner_a, want.corner_b, want.corner_c,
						got.corner_a, got.corner_b, got.corner_c);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_limit = COUNT_RESET;
			clear_window();
			expected_tris.delete();
			backlog <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_VERTEX_COUNT)
				vc_limit = pwdata[16:0] & COUNT_MASK;
			if (tri_valid && tri_ready)
				check_triangle(tri_item);
			if (idx_valid && idx_ready)
				assemble(idx_item);
			backlog <= expected_tris.size();
		end
	end

endmodule

// ===== tb/sv/tb_triangle_primitive_assembler.sv =====
`timescale 1ns / 100ps
module tb_triangle_primitive_assembler
	import tpa_pkg::*;
();

	localparam int                 LIMIT     = 1000000;
	localparam int                 LONG_HOLD = 300;
	localparam logic [PADDR_W-1:0] VC_ADDR   = {REG_VERTEX_COUNT, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               idx_valid;
	logic               idx_ready;
	idx_item_t          idx_item;
	logic               tri_valid;
	logic               tri_ready;
	tri_item_t          tri_item;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int pending_tris;
	int mismatches;
	int cycle_count;
	int holds_asked;
	int holds_served;
	int rx_wait;
	int rx_calm;
	bit gaps_on;

	triangle_primitive_assembler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.idx_valid (idx_valid),
		.idx_ready (idx_ready),
		.idx_item  (idx_item),
		.tri_valid (tri_valid),
		.tri_ready (tri_ready),
		.tri_item  (tri_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	tpa_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.idx_valid  (idx_valid),
		.idx_ready  (idx_ready),
		.idx_item   (idx_item),
		.tri_valid  (tri_valid),
		.tri_ready  (tri_ready),
		.tri_item   (tri_item),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.backlog    (pending_tris),
		.fail_count (mismatches)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// triangle sink: random stalls, calm stretches, and long holds on request
	initial begin
		holds_served = 0;
		rx_wait      = 0;
		rx_calm      = 0;
	end

	always @(posedge clk) begin
		int r;
		if (holds_served != holds_asked) begin
			holds_served++;
			rx_wait = LONG_HOLD;
			rx_calm = 0;
		end
		if (rx_wait > 0) begin
			tri_ready <= 1'b0;
			rx_wait--;
		end else if (rx_calm > 0) begin
			tri_ready <= 1'b1;
			rx_calm--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				tri_ready <= 1'b1;
			end else if (r < 85) begin
				tri_ready <= 1'b0;
				rx_wait = $urandom_range(0, 2);
			end else if (r < 92) begin
				tri_ready <= 1'b0;
				rx_wait = $urandom_range(5, 40);
			end else begin
				tri_ready <= 1'b1;
				rx_calm = $urandom_range(20, 80);
			end
		end
	end

	function automatic idx_item_t mk_idx(input logic [15:0] v, input logic lm, input logic se);
		idx_item_t t;
		t.index_value = v;
		t.list_mode   = lm;
		t.strip_end   = se;
		return t;
	endfunction

	// mostly indices around the vertex count, so bound, repeat and restart cases all show up
	function automatic logic [15:0] rand_index(input int unsigned vc);
		int unsigned r;
		int unsigned base;
		int unsigned span;
		r = $urandom_range(0, 99);
		if (r < 8)
			return RESTART_INDEX;
		if (r < 12)
			return r[0] ? 16'hFFFE : 16'h0000;
		if (r < 22) begin
			base = $urandom();
			return base[15:0];
		end
		span = (vc < 16) ? vc : 17;
		base = (vc > 65536) ? 65520 : ((vc >= 16) ? vc - 16 : 0);
		base = base + $urandom_range(0, span);
		return (base > 65535) ? RESTART_INDEX : base[15:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// called at a rising edge; returns at the edge the item is taken
	task automatic push_index(input idx_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			idx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		idx_valid <= 1'b1;
		idx_item  <= it;
		do @(posedge clk); while (!idx_ready);
	endtask

	task automatic wait_all_delivered();
		idx_valid <= 1'b0;
		@(posedge clk);
		while (pending_tris != 0) @(posedge clk);
		// index-only items may still be in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// strips of random length and mode, each usually closed by a strip end
	task automatic run_phase(input int unsigned vc, input int n, input bit hold);
		int   sent;
		int   len;
		int   style;
		int   k;
		logic lm;
		logic se;
		wait_all_delivered();
		apb_write(VC_ADDR, vc);
		if (hold)
			holds_asked++;
		sent = 0;
		while (sent < n) begin
			len     = $urandom_range(1, 12);
			style   = $urandom_range(0, 9);
			gaps_on = ($urandom_range(0, 4) != 0);
			for (k = 0; k < len; k++) begin
				lm = (style < 4) || (style == 9 && $urandom_range(0, 1) == 1);
				se = (k == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
				push_index(mk_idx(rand_index(vc), lm, se));
				sent++;
			end
		end
	endtask

	initial begin
		holds_asked = 0;
		gaps_on     = 1'b1;
		arst_n      <= 1'b0;
		idx_valid   <= 1'b0;
		idx_item    <= '0;
		tri_ready   <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strip: even and odd windows, restart, repeated corner, extreme indices
		push_index(mk_idx(16'd0, 1'b0, 1'b0));
		push_index(mk_idx(16'd1, 1'b0, 1'b0));
		push_index(mk_idx(16'd65534, 1'b0, 1'b0));
		push_index(mk_idx(16'd3, 1'b0, 1'b0));
		push_index(mk_idx(RESTART_INDEX, 1'b0, 1'b0));
		push_index(mk_idx(16'd5, 1'b0, 1'b0));
		push_index(mk_idx(16'd5, 1'b0, 1'b0));
		push_index(mk_idx(16'd6, 1'b0, 1'b0));
		push_index(mk_idx(16'd7, 1'b0, 1'b1));
		// list: good group, group holding the restart value, unfinished group at strip end
		push_index(mk_idx(16'd65534, 1'b1, 1'b0));
		push_index(mk_idx(16'd0, 1'b1, 1'b0));
		push_index(mk_idx(16'd1, 1'b1, 1'b0));
		push_index(mk_idx(16'd9, 1'b1, 1'b0));
		push_index(mk_idx(RESTART_INDEX, 1'b1, 1'b0));
		push_index(mk_idx(16'd10, 1'b1, 1'b0));
		push_index(mk_idx(16'd11, 1'b1, 1'b0));
		push_index(mk_idx(16'd12, 1'b1, 1'b1));
		// mode flips inside one strip
		push_index(mk_idx(16'd20, 1'b0, 1'b0));
		push_index(mk_idx(16'd21, 1'b1, 1'b0));
		push_index(mk_idx(16'd22, 1'b0, 1'b0));
		push_index(mk_idx(16'd23, 1'b1, 1'b0));
		push_index(mk_idx(16'd24, 1'b0, 1'b1));

		run_phase(32'h10000, 400, 1'b1);
		run_phase(32'd1, 40, 1'b0);
		run_phase(32'd0, 40, 1'b0);
		run_phase(32'h1FFFF, 350, 1'b0);
		run_phase(32'd3, 250, 1'b1);
		run_phase(32'd100, 300, 1'b0);
		run_phase(32'd65535, 270, 1'b0);
		wait_all_delivered();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
